@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/amss_pkg.sv @@
// ---------------------------------------------------------------------------
// amss_pkg
// Shared constants, codes and types of the ADC mux scan sequencer.
// ---------------------------------------------------------------------------
package amss_pkg;

    localparam int STORE_DEPTH    = 64;
    localparam int MAX_MUXES      = 8;
    localparam int MAX_MUX_INPUTS = 16;

    localparam int STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int MUX_W    = (MAX_MUXES > 1) ? $clog2(MAX_MUXES) : 1;
    localparam int MUXIN_W  = $clog2(MAX_MUX_INPUTS);

    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 12;
    localparam int IDX_W      = 6;
    localparam int SEL_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic ACT_CONV = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_MUX        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUX_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS_PER_MUX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_READING    = 3'd4;

    typedef struct packed {
        logic accept_conv;
        logic accept_read;
        logic finish_read;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
    } dp_status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               read_fresh;
        logic               read_in_range;
        logic               sample_stored;
        logic [IDX_W-1:0]   adc_channel;
        logic [SEL_W-1:0]   mux_select;
    } result_t;

endpackage

@@ hw/rtl/amss_ram.sv @@
// ---------------------------------------------------------------------------
// amss_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ---------------------------------------------------------------------------
module amss_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

@@ hw/rtl/amss_ctrl.sv @@
// ---------------------------------------------------------------------------
// amss_ctrl
// Request sequencing: conversions end at acceptance, reads via a read state.
// ---------------------------------------------------------------------------
module amss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 action,
    output logic                 in_stall,
    input  amss_pkg::dp_status_t status,
    output amss_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE) || !status.slot_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd.accept_conv = accept && (action == amss_pkg::ACT_CONV);
        cmd.accept_read = accept && (action == amss_pkg::ACT_READ);
        cmd.finish_read = (state_reg == ST_READ);
        state_next      = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept_read)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/amss_dp.sv @@
// ---------------------------------------------------------------------------
// amss_dp
// Datapath: config registers, scan counters, sample store, result buffer.
// ---------------------------------------------------------------------------
module amss_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [amss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [amss_pkg::SAMPLE_W-1:0]       sample,
    input  logic [amss_pkg::IDX_W-1:0]          read_index,
    input  amss_pkg::ctrl_cmd_t                 cmd,
    output amss_pkg::dp_status_t                status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output amss_pkg::result_t                   result
);

    localparam int SD  = amss_pkg::STORE_DEPTH;
    localparam int AW  = amss_pkg::STORE_AW;
    localparam int MW  = amss_pkg::MUX_W;
    localparam int IW  = amss_pkg::MUXIN_W;
    localparam int VW  = amss_pkg::VALUE_W;
    localparam int XW  = amss_pkg::IDX_W;

    // configuration
    logic          use_mux_reg;
    logic [3:0]    mux_count_reg;
    logic [4:0]    inputs_per_mux_reg;
    logic [6:0]    input_count_reg;
    logic [VW-1:0] max_reading_reg;

    // scan state
    logic          phase_reg,     phase_next;
    logic [XW-1:0] scan_reg,      scan_next;
    logic [MW-1:0] mux_reg,       mux_next;
    logic [IW-1:0] mux_in_reg,    mux_in_next;

    logic [SD-1:0] valid_reg;
    logic [SD-1:0] fresh_reg;

    logic          rd_range_reg;
    logic          rd_fresh_reg;
    logic          rd_valid_reg;

    logic [VW-1:0] ram_rdata;
    logic [8:0]    scan_wide;
    logic [8:0]    ridx_wide;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          keep;
    logic          store_wr;
    logic          rd_in_range;

    logic [IW:0]   next_in;
    logic [MW:0]   next_mux;
    logic [XW:0]   next_scan;

    amss_pkg::result_t conv_res;
    amss_pkg::result_t read_res;
    amss_pkg::result_t push_res;
    logic              push;
    logic              pop;

    amss_pkg::result_t head_reg, head_next;
    amss_pkg::result_t skid_reg, skid_next;
    logic              head_vld_reg, head_vld_next;
    logic              skid_vld_reg, skid_vld_next;

    assign scan_wide   = {3'b000, scan_reg};
    assign ridx_wide   = {3'b000, read_index};
    assign wr_addr     = scan_wide[AW-1:0];
    assign rd_addr     = ridx_wide[AW-1:0];
    assign rd_in_range = (ridx_wide < 9'(input_count_reg)) && (ridx_wide < 9'(SD));
    assign keep        = phase_reg && ({4'b0000, max_reading_reg} >= sample);

    // scan position update
    always_comb
    begin
        phase_next  = phase_reg;
        scan_next   = scan_reg;
        mux_next    = mux_reg;
        mux_in_next = mux_in_reg;
        next_in     = {1'b0, mux_in_reg} + 1'b1;
        next_mux    = {1'b0, mux_reg} + 1'b1;
        next_scan   = {1'b0, scan_reg} + 1'b1;
        if (cmd.accept_conv)
        begin
            phase_next = ~phase_reg;
            if (keep)
            begin
                if (use_mux_reg)
                begin
                    scan_next = next_scan[XW-1:0];
                    if ((8'(next_in) >= 8'(inputs_per_mux_reg))
                        || (8'(next_in) >= 8'(amss_pkg::MAX_MUX_INPUTS)))
                    begin
                        mux_in_next = '0;
                        if ((8'(next_mux) >= 8'(mux_count_reg))
                            || (8'(next_mux) >= 8'(amss_pkg::MAX_MUXES)))
                        begin
                            mux_next  = '0;
                            scan_next = '0;
                        end
                        else
                        begin
                            mux_next = next_mux[MW-1:0];
                        end
                    end
                    else
                    begin
                        mux_in_next = next_in[IW-1:0];
                    end
                end
                else
                begin
                    if (next_scan[XW] || (next_scan >= input_count_reg))
                    begin
                        scan_next = '0;
                    end
                    else
                    begin
                        scan_next = next_scan[XW-1:0];
                    end
                end
            end
        end
    end

    assign store_wr = cmd.accept_conv && keep && (scan_wide < 9'(SD));

    amss_ram #(
        .WIDTH (VW),
        .DEPTH (SD)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (wr_addr),
        .wr_data (sample[VW-1:0]),
        .rd_en   (cmd.accept_read),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // result formation
    always_comb
    begin
        conv_res               = '0;
        conv_res.sample_stored = keep;
        if (use_mux_reg)
        begin
            conv_res.adc_channel = XW'(mux_next);
            conv_res.mux_select  = amss_pkg::SEL_W'(mux_in_next);
        end
        else
        begin
            conv_res.adc_channel = scan_next;
        end

        read_res               = '0;
        read_res.read_in_range = rd_range_reg;
        read_res.read_fresh    = rd_fresh_reg;
        read_res.read_value    = (rd_range_reg && rd_valid_reg) ? ram_rdata : '0;
        if (use_mux_reg)
        begin
            read_res.adc_channel = XW'(mux_reg);
            read_res.mux_select  = amss_pkg::SEL_W'(mux_in_reg);
        end
        else
        begin
            read_res.adc_channel = scan_reg;
        end

        push     = cmd.accept_conv || cmd.finish_read;
        push_res = cmd.finish_read ? read_res : conv_res;
    end

    // two-entry result buffer
    assign pop              = head_vld_reg && !out_stall;
    assign out_valid        = head_vld_reg;
    assign result           = head_reg;
    assign status.slot_free = !skid_vld_reg;

    always_comb
    begin
        head_next     = head_reg;
        skid_next     = skid_reg;
        head_vld_next = head_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (pop)
        begin
            if (skid_vld_reg)
            begin
                head_next     = skid_reg;
                skid_vld_next = 1'b0;
            end
            else
            begin
                head_vld_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!head_vld_next)
            begin
                head_next     = push_res;
                head_vld_next = 1'b1;
            end
            else
            begin
                skid_next     = push_res;
                skid_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
        if (cmd.accept_read)
        begin
            rd_range_reg <= rd_in_range;
            rd_fresh_reg <= rd_in_range && fresh_reg[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_mux_reg        <= 1'b0;
            mux_count_reg      <= 4'd1;
            inputs_per_mux_reg <= 5'd16;
            input_count_reg    <= 7'd8;
            max_reading_reg    <= 12'd4095;
            phase_reg          <= 1'b0;
            scan_reg           <= '0;
            mux_reg            <= '0;
            mux_in_reg         <= '0;
            valid_reg          <= '0;
            fresh_reg          <= '0;
            head_vld_reg       <= 1'b0;
            skid_vld_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    amss_pkg::CFG_USE_MUX:        use_mux_reg        <= cfg_data[0];
                    amss_pkg::CFG_MUX_COUNT:      mux_count_reg      <= cfg_data[3:0];
                    amss_pkg::CFG_INPUTS_PER_MUX: inputs_per_mux_reg <= cfg_data[4:0];
                    amss_pkg::CFG_INPUT_COUNT:    input_count_reg    <= cfg_data[6:0];
                    amss_pkg::CFG_MAX_READING:    max_reading_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg    <= phase_next;
            scan_reg     <= scan_next;
            mux_reg      <= mux_next;
            mux_in_reg   <= mux_in_next;
            head_vld_reg <= head_vld_next;
            skid_vld_reg <= skid_vld_next;
            if (store_wr)
            begin
                valid_reg[wr_addr] <= 1'b1;
                fresh_reg[wr_addr] <= 1'b1;
            end
            if (cmd.accept_read && rd_in_range)
            begin
                fresh_reg[rd_addr] <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/adc_mux_scan_sequencer_unit.sv @@
// ---------------------------------------------------------------------------
// adc_mux_scan_sequencer_unit
// ADC scan sequencer, direct or through analog multiplexers, with store.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | action, sample, read_index
//  out     | out_valid/out_stall | read_value, read_fresh, read_in_range,
//          |                     | sample_stored, adc_channel, mux_select
//  cfg     | cfg_write           | cfg_index, cfg_data
//
//  Conversion request: its result is registered at acceptance.
//  Read request: finishes in the read state, after the registered store read.
//  Reset clears the store at once through per-entry valid flops.
//  A two-entry result buffer lets a request enter while a result waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_mux_scan_sequencer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [amss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [amss_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [amss_pkg::SAMPLE_W-1:0]    sample,
    input  logic [amss_pkg::IDX_W-1:0]       read_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [amss_pkg::VALUE_W-1:0]     read_value,
    output logic                             read_fresh,
    output logic                             read_in_range,
    output logic                             sample_stored,
    output logic [amss_pkg::IDX_W-1:0]       adc_channel,
    output logic [amss_pkg::SEL_W-1:0]       mux_select
);

    amss_pkg::ctrl_cmd_t  cmd;
    amss_pkg::dp_status_t status;
    amss_pkg::result_t    result;

    amss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    amss_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .read_index (read_index),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign read_value    = result.read_value;
    assign read_fresh    = result.read_fresh;
    assign read_in_range = result.read_in_range;
    assign sample_stored = result.sample_stored;
    assign adc_channel   = result.adc_channel;
    assign mux_select    = result.mux_select;

    `ASSERT_CLK(a_read_blocks_next, clk, rst_n, cmd.accept_read |=> in_stall)
    `ASSERT_CLK(a_finish_after_read, clk, rst_n, cmd.finish_read |-> $past(cmd.accept_read))
    `ASSERT_CLK(a_conv_gives_result, clk, rst_n, cmd.accept_conv |=> out_valid)
    `ASSERT_NEVER(a_no_double_accept, clk, rst_n, cmd.accept_conv && cmd.accept_read)

endmodule

@@ bench/adc_mux_scan_sequencer_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adc_mux_scan_sequencer_unit_test
// Self-checking bench for the ADC mux scan sequencer. An opening script of
// requests covers reset contents, discards, rejects, reads and the direct
// wrap; random phases then sweep the register settings in direct and mux
// mode. Fixed results check the typed script rows and an in-bench model the
// rest, while both handshakes idle and stall in random bursts.
// ---------------------------------------------------------------------------
module adc_mux_scan_sequencer_unit_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 50;
    localparam int SCRIPT_ROWS  = 26;

    typedef struct packed {
        logic                          act;
        logic [amss_pkg::SAMPLE_W-1:0] smp;
        logic [amss_pkg::IDX_W-1:0]    idx;
        logic                          typed;
        amss_pkg::result_t             want;
    } script_row_t;

    typedef struct packed {
        logic       use_mux;
        logic [3:0] mux_count;
        logic [4:0] inputs_per_mux;
        logic [6:0] input_count;
        logic [11:0] max_reading;
    } setting_t;

    localparam amss_pkg::result_t UNCHECKED = '0;

    localparam script_row_t OPENING_SCRIPT [SCRIPT_ROWS] = '{
        '{amss_pkg::ACT_READ, 16'h0000, 6'd0,  1'b1, '{12'd0, 1'b0, 1'b1, 1'b0, 6'd0, 4'd0}},
        '{amss_pkg::ACT_READ, 16'h0000, 6'd63, 1'b1, '{12'd0, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}},
        '{amss_pkg::ACT_READ, 16'hFFFF, 6'd8,  1'b1, '{12'd0, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}},
        '{amss_pkg::ACT_CONV, 16'd100,  6'd0,  1'b1, '{12'd0, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}},
        '{amss_pkg::ACT_CONV, 16'd4095, 6'd63, 1'b1, '{12'd0, 1'b0, 1'b0, 1'b1, 6'd1, 4'd0}},
        '{amss_pkg::ACT_CONV, 16'hFFFF, 6'd0,  1'b1, '{12'd0, 1'b0, 1'b0, 1'b0, 6'd1, 4'd0}},
        '{amss_pkg::ACT_CONV, 16'd4096, 6'd0,  1'b1, '{12'd0, 1'b0, 1'b0, 1'b0, 6'd1, 4'd0}},
        '{amss_pkg::ACT_CONV, 16'h0000, 6'd0,  1'b1, '{12'd0, 1'b0, 1'b0, 1'b0, 6'd1, 4'd0}},
        '{amss_pkg::ACT_CONV, 16'h0000, 6'd0,  1'b1, '{12'd0, 1'b0, 1'b0, 1'b1, 6'd2, 4'd0}},
        '{amss_pkg::ACT_READ, 16'h0000, 6'd0,  1'b1, '{12'd4095, 1'b1, 1'b1, 1'b0, 6'd2, 4'd0}},
        '{amss_pkg::ACT_READ, 16'h0000, 6'd0,  1'b1, '{12'd4095, 1'b0, 1'b1, 1'b0, 6'd2, 4'd0}},
        '{amss_pkg::ACT_READ, 16'h0000, 6'd1,  1'b1, '{12'd0, 1'b1, 1'b1, 1'b0, 6'd2, 4'd0}},
        '{amss_pkg::ACT_READ, 16'h0000, 6'd7,  1'b1, '{12'd0, 1'b0, 1'b1, 1'b0, 6'd2, 4'd0}},
        '{amss_pkg::ACT_CONV, 16'h8000, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'h0AAA, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'hF555, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'h0555, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'h8000, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'h0FFF, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'hFFFF, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'h0001, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'h7000, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'h0800, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'h1234, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_CONV, 16'h07FF, 6'd0,  1'b0, UNCHECKED},
        '{amss_pkg::ACT_READ, 16'h0000, 6'd6,  1'b0, UNCHECKED}
    };

    // low and high extremes first, then mixed corners
    localparam setting_t FIXED_SETTINGS [5] = '{
        '{1'b0, 4'd1, 5'd1,  7'd1,  12'd0},
        '{1'b1, 4'd8, 5'd16, 7'd64, 12'd4095},
        '{1'b1, 4'd1, 5'd1,  7'd5,  12'd1023},
        '{1'b1, 4'd2, 5'd16, 7'd64, 12'd4095},
        '{1'b0, 4'd8, 5'd16, 7'd64, 12'd1023}
    };

    logic                            clk;
    logic                            rst_n      = 1'b0;
    logic                            cfg_write  = 1'b0;
    logic [amss_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [amss_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic                            action     = amss_pkg::ACT_CONV;
    logic [amss_pkg::SAMPLE_W-1:0]   sample     = '0;
    logic [amss_pkg::IDX_W-1:0]      read_index = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic [amss_pkg::VALUE_W-1:0]    read_value;
    logic                            read_fresh;
    logic                            read_in_range;
    logic                            sample_stored;
    logic [amss_pkg::IDX_W-1:0]      adc_channel;
    logic [amss_pkg::SEL_W-1:0]      mux_select;

    // sequencer state as the bench sees it
    logic [amss_pkg::VALUE_W:0]      store_copy [amss_pkg::STORE_DEPTH] = '{default: '0};
    logic                            conv_phase    = 1'b0;
    logic [amss_pkg::IDX_W-1:0]      scan_pos      = '0;
    logic [amss_pkg::MUX_W-1:0]      mux_pos       = '0;
    logic [amss_pkg::MUXIN_W-1:0]    mux_in_pos    = '0;
    logic                            cur_use_mux        = 1'b0;
    logic [3:0]                      cur_mux_count      = 4'd1;
    logic [4:0]                      cur_inputs_per_mux = 5'd16;
    logic [6:0]                      cur_input_count    = 7'd8;
    logic [11:0]                     cur_max_reading    = 12'd4095;

    amss_pkg::result_t     awaited_results [$];
    int                    mismatches  = 0;
    int                    cycle_count = 0;
    int                    gap_pct     = 25;
    int                    stall_pct   = 25;
    int                    stall_left  = 0;

    adc_mux_scan_sequencer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .sample        (sample),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .read_fresh    (read_fresh),
        .read_in_range (read_in_range),
        .sample_stored (sample_stored),
        .adc_channel   (adc_channel),
        .mux_select    (mux_select)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic amss_pkg::result_t sequencer_step(
        input logic                          act,
        input logic [amss_pkg::SAMPLE_W-1:0] smp,
        input logic [amss_pkg::IDX_W-1:0]    idx);
        amss_pkg::result_t          r;
        int                         next_in;
        int                         next_mux;
        logic [amss_pkg::IDX_W-1:0] next_index;
        r = '0;
        if (act == amss_pkg::ACT_READ)
        begin
            if (int'(idx) < int'(cur_input_count) && int'(idx) < amss_pkg::STORE_DEPTH)
            begin
                r.read_in_range = 1'b1;
                r.read_value    = store_copy[idx][amss_pkg::VALUE_W-1:0];
                r.read_fresh    = store_copy[idx][amss_pkg::VALUE_W];
                store_copy[idx][amss_pkg::VALUE_W] = 1'b0;
            end
        end
        else
        begin
            conv_phase = ~conv_phase;
            if (!conv_phase && smp <= cur_max_reading)
            begin
                if (int'(scan_pos) < amss_pkg::STORE_DEPTH)
                    store_copy[scan_pos] = {1'b1, smp[amss_pkg::VALUE_W-1:0]};
                r.sample_stored = 1'b1;
                next_index = scan_pos + 1'b1;
                if (cur_use_mux)
                begin
                    next_in  = int'(mux_in_pos) + 1;
                    scan_pos = next_index;
                    if (next_in >= int'(cur_inputs_per_mux)
                        || next_in >= amss_pkg::MAX_MUX_INPUTS)
                    begin
                        next_mux   = int'(mux_pos) + 1;
                        mux_in_pos = '0;
                        if (next_mux >= int'(cur_mux_count) || next_mux >= amss_pkg::MAX_MUXES)
                        begin
                            mux_pos  = '0;
                            scan_pos = '0;
                        end
                        else
                            mux_pos = next_mux[amss_pkg::MUX_W-1:0];
                    end
                    else
                        mux_in_pos = next_in[amss_pkg::MUXIN_W-1:0];
                end
                else if (next_index == '0 || int'(scan_pos) + 1 >= int'(cur_input_count))
                    scan_pos = '0;
                else
                    scan_pos = next_index;
            end
        end
        r.adc_channel = cur_use_mux ? amss_pkg::IDX_W'(mux_pos) : scan_pos;
        r.mux_select  = cur_use_mux ? amss_pkg::SEL_W'(mux_in_pos) : '0;
        return r;
    endfunction

    task automatic issue_request(input logic act, input logic [amss_pkg::SAMPLE_W-1:0] smp,
                                 input logic [amss_pkg::IDX_W-1:0] idx, input logic typed,
                                 input amss_pkg::result_t typed_result);
        amss_pkg::result_t predicted;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        sample     <= smp;
        read_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = sequencer_step(act, smp, idx);
        awaited_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic write_register(input logic [amss_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [11:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            amss_pkg::CFG_USE_MUX:        cur_use_mux        = data[0];
            amss_pkg::CFG_MUX_COUNT:      cur_mux_count      = data[3:0];
            amss_pkg::CFG_INPUTS_PER_MUX: cur_inputs_per_mux = data[4:0];
            amss_pkg::CFG_INPUT_COUNT:    cur_input_count    = data[6:0];
            amss_pkg::CFG_MAX_READING:    cur_max_reading    = data[11:0];
            default:            ;
        endcase
    endtask

    task automatic apply_setting(input setting_t s);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        write_register(amss_pkg::CFG_USE_MUX,        12'(s.use_mux));
        write_register(amss_pkg::CFG_MUX_COUNT,      12'(s.mux_count));
        write_register(amss_pkg::CFG_INPUTS_PER_MUX, 12'(s.inputs_per_mux));
        write_register(amss_pkg::CFG_INPUT_COUNT,    12'(s.input_count));
        write_register(amss_pkg::CFG_MAX_READING,    s.max_reading);
        cfg_write <= 1'b0;
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    initial
    begin : stimulus
        setting_t                      s;
        logic                          act;
        logic [amss_pkg::SAMPLE_W-1:0] smp;
        logic [amss_pkg::IDX_W-1:0]    idx;
        int                            pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < SCRIPT_ROWS; k++)
            issue_request(OPENING_SCRIPT[k].act, OPENING_SCRIPT[k].smp, OPENING_SCRIPT[k].idx,
                          OPENING_SCRIPT[k].typed, OPENING_SCRIPT[k].want);
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 5)
                s = FIXED_SETTINGS[p];
            else
            begin
                s.use_mux        = 1'($urandom_range(0, 1));
                s.mux_count      = 4'($urandom_range(1, 8));
                s.inputs_per_mux = 5'($urandom_range(1, 16));
                s.input_count    = 7'($urandom_range(1, 64));
                pick             = $urandom_range(0, 2);
                s.max_reading    = (pick == 0) ? 12'd1023 :
                                   (pick == 1) ? 12'd4095 : 12'($urandom_range(0, 4095));
            end
            if (p == PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                pick      = $urandom_range(0, 2);
                gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
                pick      = $urandom_range(0, 2);
                stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            end
            apply_setting(s);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                act  = ($urandom_range(0, 99) < 35) ? amss_pkg::ACT_READ : amss_pkg::ACT_CONV;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    smp = 16'($urandom_range(0, 65535));
                else if (pick == 1)
                    smp = 16'($urandom_range(int'(cur_max_reading) + 1, 65535));
                else if (pick == 2)
                    smp = 16'(cur_max_reading);
                else
                    smp = 16'($urandom_range(0, int'(cur_max_reading)));
                if ($urandom_range(0, 3) == 0)
                    idx = 6'($urandom_range(0, 63));
                else
                    idx = 6'($urandom_range(0, int'(cur_input_count) - 1));
                issue_request(act, smp, idx, 1'b0, UNCHECKED);
            end
        end
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS adc_mux_scan_sequencer_unit");
        else
            $display("FAIL adc_mux_scan_sequencer_unit");
        $finish;
    end

    initial
    begin : result_backpressure
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
                stall_left = $urandom_range(1, 18);
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin : check_results
        amss_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("read_value",    want.read_value,    read_value);
                compare_field("read_fresh",    want.read_fresh,    read_fresh);
                compare_field("read_in_range", want.read_in_range, read_in_range);
                compare_field("sample_stored", want.sample_stored, sample_stored);
                compare_field("adc_channel",   want.adc_channel,   adc_channel);
                compare_field("mux_select",    want.mux_select,    mux_select);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL adc_mux_scan_sequencer_unit");
            $finish;
        end
    end

endmodule
